FILE: design/lsps_pkg.sv
// Shared types, codes and defaults of the loop-stack primitive sequencer.
package lsps_pkg;

  localparam int PROG_DEPTH_DEF = 256;
  localparam int NEST_DEPTH_DEF = 16;

  localparam int OPC_W = 3;
  localparam int ARG_W = 16;
  localparam int CNT_W = 32;
  localparam int CNT_NUM = 6;
  localparam int SEL_W = 3;

  // operation codes of an input word
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_NEXT    = 2'd2;

  // program opcodes
  localparam logic [OPC_W-1:0] OPC_HALT  = 3'd0;
  localparam logic [OPC_W-1:0] OPC_DOOP  = 3'd1;
  localparam logic [OPC_W-1:0] OPC_LOOP  = 3'd2;
  localparam logic [OPC_W-1:0] OPC_END   = 3'd3;
  localparam logic [OPC_W-1:0] OPC_BLOCK = 3'd4;
  localparam logic [OPC_W-1:0] OPC_SEND  = 3'd5;
  localparam logic [OPC_W-1:0] OPC_RECV  = 3'd6;

  // result status codes
  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_HALT      = 3'd1;
  localparam logic [2:0] STS_UNKNOWN   = 3'd2;
  localparam logic [2:0] STS_OVERFLOW  = 3'd3;
  localparam logic [2:0] STS_UNDERFLOW = 3'd4;
  localparam logic [2:0] STS_RANGE     = 3'd5;

  // statistic counter indexes
  localparam logic [SEL_W-1:0] CNT_RUN         = 3'd0;
  localparam logic [SEL_W-1:0] CNT_RUN_TIME    = 3'd1;
  localparam logic [SEL_W-1:0] CNT_WAIT        = 3'd2;
  localparam logic [SEL_W-1:0] CNT_BLOCK_TICKS = 3'd3;
  localparam logic [SEL_W-1:0] CNT_SEND        = 3'd4;
  localparam logic [SEL_W-1:0] CNT_RECV        = 3'd5;

  typedef struct packed {
    logic [1:0]       operation;
    logic [7:0]       load_address;
    logic [OPC_W-1:0] load_opcode;
    logic [ARG_W-1:0] load_argument;
  } lsps_cmd_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [OPC_W-1:0] primitive_res;
    logic [ARG_W-1:0] duration;
    logic [7:0]       pointer;
    logic [CNT_W-1:0] run_count;
    logic [CNT_W-1:0] run_time;
    logic [CNT_W-1:0] wait_count;
    logic [CNT_W-1:0] block_ticks;
    logic [CNT_W-1:0] sends_seen;
    logic [CNT_W-1:0] receives_seen;
  } lsps_res_t;

  typedef logic [CNT_NUM-1:0][CNT_W-1:0] cnt_bank_t;

  typedef struct packed {
    logic             clear;
    logic             add;
    logic [SEL_W-1:0] sel;
    logic [CNT_W-1:0] operand;
  } stat_cmd_t;

endpackage

FILE: design/lsps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lsps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/lsps_stats.sv
// Statistic counter bank behind one shared saturating adder.
module lsps_stats (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lsps_pkg::stat_cmd_t   cmd_i,
  output lsps_pkg::cnt_bank_t   cnt_o
);
  import lsps_pkg::*;

  cnt_bank_t        cnt_q;
  logic [CNT_W:0]   sum;
  logic [CNT_W-1:0] sat_sum;
  logic             sel_ok;

  assign sel_ok  = cmd_i.sel < SEL_W'(CNT_NUM);
  assign sum     = {1'b0, cnt_q[cmd_i.sel]} + {1'b0, cmd_i.operand};
  // clamp at all ones on carry out
  assign sat_sum = sum[CNT_W] ? '1 : sum[CNT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.clear) begin
      cnt_q <= '0;
    end else if (cmd_i.add && sel_ok) begin
      cnt_q[cmd_i.sel] <= sat_sum;
    end
  end

  assign cnt_o = cnt_q;

endmodule

FILE: design/loop_stack_primitive_sequencer.sv
// Loop-stack primitive sequencer: program store, loop stack and walk control.
//
//  port group     dir  handshake        payload
//  command        in   start / busy     cmd_i  (lsps_cmd_t)
//  result         out  done_o strobe    res_o  (lsps_res_t)
//
// Load, restart and no-op words need no walk; the result strobes in the next cycle.
// A next word walks each program word through a fetch state, then an execute
// state on the registered read of the program memory; DOOP and BLOCK add a
// time state, since their two counter updates share one saturating adder.
// The result strobes in the cycle after the last step; busy is high meanwhile.
// Reset puts the pointer before the first word and clears stack depth and
// counters; program and stack memories are not cleared. No stall on results.
module loop_stack_primitive_sequencer #(
  parameter int PROGRAM_DEPTH   = lsps_pkg::PROG_DEPTH_DEF,
  parameter int LOOP_NEST_DEPTH = lsps_pkg::NEST_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  lsps_pkg::lsps_cmd_t cmd_i,
  output logic                busy,
  output logic                done_o,
  output lsps_pkg::lsps_res_t res_o
);
  import lsps_pkg::*;

  localparam int AW  = $clog2(PROGRAM_DEPTH);
  localparam int IPW = $clog2(PROGRAM_DEPTH + 1) + 1;
  localparam int SAW = (LOOP_NEST_DEPTH > 1) ? $clog2(LOOP_NEST_DEPTH) : 1;
  localparam int SDW = $clog2(LOOP_NEST_DEPTH + 1);
  localparam int PWW = OPC_W + ARG_W;
  localparam int SEW = AW + ARG_W;

  typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_EXEC, ST_TIME} state_e;

  state_e                     state_q;
  logic [IPW-1:0]             ip_q;
  logic [SDW-1:0]             depth_q;
  logic [LOOP_NEST_DEPTH-1:0] fresh_q;
  logic                       done_q;
  logic [2:0]                 status_q;
  logic [OPC_W-1:0]           prim_q;
  logic [ARG_W-1:0]           dur_q;
  logic [7:0]                 ptr_q;

  logic             accept;
  logic [IPW-1:0]   ip_nxt;
  logic             ip_off;
  logic [31:0]      la_ext;
  logic [31:0]      ip_ext;
  logic             prog_we;
  logic [PWW-1:0]   prog_rdata;
  logic [OPC_W-1:0] word_opc;
  logic [ARG_W-1:0] word_arg;

  logic [SDW-1:0]   depth_m1;
  logic [SAW-1:0]   top_idx;
  logic [SAW-1:0]   push_idx;
  logic             depth_full;
  logic             depth_empty;
  logic [SEW-1:0]   stk_rdata;
  logic [AW-1:0]    top_start;
  logic [ARG_W-1:0] top_count;
  logic             end_pop;
  logic             stk_we;
  logic [SAW-1:0]   stk_waddr;
  logic [SEW-1:0]   stk_wdata;

  stat_cmd_t        stat_cmd;
  cnt_bank_t        cnt;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign ip_nxt = ip_q + IPW'(1);
  assign ip_off = ip_nxt >= IPW'(PROGRAM_DEPTH);
  assign la_ext = 32'(cmd_i.load_address);
  assign ip_ext = 32'(ip_q);

  // drop loads beyond the program
  assign prog_we = accept && (cmd_i.operation == OP_LOAD) && (la_ext < 32'(PROGRAM_DEPTH));

  lsps_ram #(
    .WIDTH (PWW),
    .DEPTH (PROGRAM_DEPTH)
  ) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (prog_we),
    .waddr_i (la_ext[AW-1:0]),
    .wdata_i ({cmd_i.load_opcode, cmd_i.load_argument}),
    .raddr_i (ip_nxt[AW-1:0]),
    .rdata_o (prog_rdata)
  );

  assign word_opc = prog_rdata[PWW-1:ARG_W];
  assign word_arg = prog_rdata[ARG_W-1:0];

  assign depth_m1    = depth_q - SDW'(1);
  assign top_idx     = depth_m1[SAW-1:0];
  assign push_idx    = depth_q[SAW-1:0];
  assign depth_full  = (depth_q == SDW'(LOOP_NEST_DEPTH));
  assign depth_empty = (depth_q == '0);
  assign top_start   = stk_rdata[SEW-1:ARG_W];
  assign top_count   = stk_rdata[ARG_W-1:0];
  // a body that ran through without a stop repeats identically: leave at once
  assign end_pop     = fresh_q[top_idx] || (top_count <= ARG_W'(1));

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = push_idx;
    stk_wdata = {ip_q[AW-1:0], word_arg};
    if (state_q == ST_EXEC) begin
      if (word_opc == OPC_LOOP && !depth_full) begin
        stk_we = 1'b1;
      end else if (word_opc == OPC_END && !depth_empty && !end_pop) begin
        stk_we    = 1'b1;
        stk_waddr = top_idx;
        stk_wdata = {top_start, top_count - ARG_W'(1)};
      end
    end
  end

  lsps_ram #(
    .WIDTH (SEW),
    .DEPTH (LOOP_NEST_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (top_idx),
    .rdata_o (stk_rdata)
  );

  always_comb begin
    stat_cmd = '{clear: 1'b0, add: 1'b0, sel: CNT_RUN, operand: '0};
    case (state_q)
      ST_IDLE: begin
        stat_cmd.clear = accept && (cmd_i.operation == OP_RESTART);
      end
      ST_EXEC: begin
        stat_cmd.operand = CNT_W'(1);
        case (word_opc)
          OPC_DOOP: begin
            stat_cmd.add = 1'b1;
            stat_cmd.sel = CNT_RUN;
          end
          OPC_BLOCK: begin
            stat_cmd.add = 1'b1;
            stat_cmd.sel = CNT_WAIT;
          end
          OPC_SEND: begin
            stat_cmd.add = 1'b1;
            stat_cmd.sel = CNT_SEND;
          end
          OPC_RECV: begin
            stat_cmd.add = 1'b1;
            stat_cmd.sel = CNT_RECV;
          end
          default: begin
            stat_cmd.add = 1'b0;
          end
        endcase
      end
      ST_TIME: begin
        stat_cmd.add     = 1'b1;
        stat_cmd.sel     = (prim_q == OPC_DOOP) ? CNT_RUN_TIME : CNT_BLOCK_TICKS;
        stat_cmd.operand = CNT_W'(dur_q);
      end
      default: begin
        stat_cmd.add = 1'b0;
      end
    endcase
  end

  lsps_stats u_stats (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (stat_cmd),
    .cnt_o  (cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ip_q     <= '1;
      depth_q  <= '0;
      fresh_q  <= '0;
      done_q   <= 1'b0;
      status_q <= STS_OK;
      prim_q   <= OPC_HALT;
      dur_q    <= '0;
      ptr_q    <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (cmd_i.operation == OP_NEXT) begin
              fresh_q <= '0;
              state_q <= ST_FETCH;
            end else begin
              if (cmd_i.operation == OP_RESTART) begin
                ip_q    <= '1;
                depth_q <= '0;
              end
              done_q   <= 1'b1;
              status_q <= STS_OK;
              prim_q   <= OPC_HALT;
              dur_q    <= '0;
              ptr_q    <= '0;
            end
          end
        end
        ST_FETCH: begin
          if (ip_off) begin
            // pin the pointer past the end
            ip_q     <= IPW'(PROGRAM_DEPTH);
            done_q   <= 1'b1;
            status_q <= STS_RANGE;
            prim_q   <= OPC_HALT;
            dur_q    <= '0;
            ptr_q    <= 8'(PROGRAM_DEPTH);
            state_q  <= ST_IDLE;
          end else begin
            ip_q    <= ip_nxt;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          prim_q   <= word_opc;
          dur_q    <= word_arg;
          ptr_q    <= ip_ext[7:0];
          status_q <= STS_OK;
          case (word_opc)
            OPC_LOOP: begin
              if (depth_full) begin
                status_q <= STS_OVERFLOW;
                done_q   <= 1'b1;
                state_q  <= ST_IDLE;
              end else begin
                fresh_q[push_idx] <= 1'b1;
                depth_q           <= depth_q + SDW'(1);
                state_q           <= ST_FETCH;
              end
            end
            OPC_END: begin
              if (depth_empty) begin
                status_q <= STS_UNDERFLOW;
                done_q   <= 1'b1;
                state_q  <= ST_IDLE;
              end else if (end_pop) begin
                depth_q <= depth_m1;
                state_q <= ST_FETCH;
              end else begin
                ip_q             <= IPW'(top_start);
                fresh_q[top_idx] <= 1'b1;
                state_q          <= ST_FETCH;
              end
            end
            OPC_DOOP, OPC_BLOCK: begin
              state_q <= ST_TIME;
            end
            OPC_SEND, OPC_RECV: begin
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end
            OPC_HALT: begin
              status_q <= STS_HALT;
              done_q   <= 1'b1;
              state_q  <= ST_IDLE;
            end
            default: begin
              status_q <= STS_UNKNOWN;
              done_q   <= 1'b1;
              state_q  <= ST_IDLE;
            end
          endcase
        end
        ST_TIME: begin
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o = done_q;

  assign res_o.status        = status_q;
  assign res_o.primitive_res = prim_q;
  assign res_o.duration      = dur_q;
  assign res_o.pointer       = ptr_q;
  assign res_o.run_count     = cnt[CNT_RUN];
  assign res_o.run_time      = cnt[CNT_RUN_TIME];
  assign res_o.wait_count    = cnt[CNT_WAIT];
  assign res_o.block_ticks   = cnt[CNT_BLOCK_TICKS];
  assign res_o.sends_seen    = cnt[CNT_SEND];
  assign res_o.receives_seen = cnt[CNT_RECV];

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while walking");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= SDW'(LOOP_NEST_DEPTH))
    else $error("loop stack depth beyond nest limit");

  a_ack_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.operation != OP_NEXT) |=> done_o && res_o.status == STS_OK)
    else $error("missing acknowledge word");

  a_restart_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.operation == OP_RESTART) |=>
      (res_o.run_count == '0 && res_o.block_ticks == '0 && res_o.receives_seen == '0))
    else $error("counters not cleared by restart");

  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.operation == OP_NEXT) |=> (busy && !done_o))
    else $error("next word not walked");

endmodule
